/* rtl/core/stereo_linear_fade_gain_top_macros.svh */
// Assertion macros shared by the fade gain modules.
// Each macro expects aclk and aresetn to be visible in the module that uses it.
`ifndef STEREO_LINEAR_FADE_GAIN_TOP_MACROS_SVH
`define STEREO_LINEAR_FADE_GAIN_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLFG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLFG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/slfg_pkg.sv */
package slfg_pkg;

    // Field widths.
    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 17;
    localparam int FRAC_W    = 16;
    localparam int CFG_W     = 17;
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
    localparam int SHIFT_W   = PROD_W - FRAC_W;

    // One integer quotient bit plus the fraction bits.
    localparam int DIV_STEPS = GAIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << FRAC_W;
    localparam logic [GAIN_W-1:0] GAIN_ZERO = '0;
    localparam logic [CFG_W-1:0]  FADE_LENGTH_RESET = CFG_W'(4096);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_IN   = 2'd1,
        MODE_OUT  = 2'd2
    } fade_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_L,
        ST_MUL_R,
        ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic load_sample;
        logic div_step;
        logic mul_left;
        logic mul_right;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } dp_status_t;

    // Floor shift by the gain fraction, then clamp to a signed sample.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [SHIFT_W-1:0] shifted;
        logic                      fits;
        shifted = prod[PROD_W-1:FRAC_W];
        fits = (shifted[SHIFT_W-1:SAMPLE_W-1] == '0)
            || (shifted[SHIFT_W-1:SAMPLE_W-1] == '1);
        if (fits) begin
            sat_sample = shifted[SAMPLE_W-1:0];
        end else if (shifted[SHIFT_W-1]) begin
            sat_sample = SAMPLE_MIN;
        end else begin
            sat_sample = SAMPLE_MAX;
        end
    endfunction

endpackage

/* rtl/core/slfg_ctrl.sv */
`include "stereo_linear_fade_gain_top_macros.svh"

module slfg_ctrl
    import slfg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       kind,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (kind) begin
                        cmd.start = 1'b1;
                    end else begin
                        cmd.load_sample = 1'b1;
                        state_next = status.need_div ? ST_DIV : ST_MUL_L;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_L: begin
                cmd.mul_left = 1'b1;
                state_next = ST_MUL_R;
            end
            ST_MUL_R: begin
                cmd.mul_right = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SLFG_ASSERT_NEXT(a_held_gain_skips_div, cmd.load_sample && !status.need_div, state_reg == ST_MUL_L, "sample without division did not go to multiply")
    `SLFG_ASSERT_NEXT(a_fin_returns_idle, (state_reg == ST_FIN) && status.out_free, s_tready, "controller did not return to idle after output load")

endmodule

/* rtl/core/slfg_datapath.sv */
`include "stereo_linear_fade_gain_top_macros.svh"

module slfg_datapath
    import slfg_pkg::*;
#(
    parameter int MAX_FADE_LENGTH = 65536
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_W-1:0]           cfg_wr_data,
    input  logic                       fade_direction,
    input  logic signed [SAMPLE_W-1:0] left_in,
    input  logic signed [SAMPLE_W-1:0] right_in,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 status,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] left_out,
    output logic signed [SAMPLE_W-1:0] right_out,
    output logic                       fade_active
);

    localparam int          LEN_RAW  = $clog2(MAX_FADE_LENGTH + 1);
    localparam int          LEN_W    = (LEN_RAW < CFG_W) ? LEN_RAW : CFG_W;
    localparam logic [31:0] MAX_LEN32 = 32'(MAX_FADE_LENGTH);

    logic [CFG_W-1:0]           fade_length_reg;
    fade_mode_t                 mode_reg;
    logic [LEN_W-1:0]           pos_reg;
    logic [GAIN_W-1:0]          held_gain_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic                       act_reg;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;
    logic [LEN_W:0]             rem_reg;
    logic [GAIN_W-1:0]          quo_reg;
    logic [CNT_W-1:0]           div_cnt_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] left_res_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_left_reg;
    logic signed [SAMPLE_W-1:0] m_right_reg;
    logic                       m_active_reg;

    logic [LEN_W-1:0]           len_eff;
    logic                       fading;
    logic                       at_end;
    logic [LEN_W-1:0]           pos_inc;
    logic [LEN_W-1:0]           num;
    logic [GAIN_W-1:0]          final_gain;
    logic [LEN_W:0]             trial;
    logic                       qbit;
    logic signed [SAMPLE_W-1:0] mul_a;
    logic signed [PROD_W-1:0]   product;

    // Effective ramp length, clamped to 1 .. MAX_FADE_LENGTH.
    always_comb begin
        if (fade_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(fade_length_reg) > MAX_LEN32) begin
            len_eff = LEN_W'(MAX_FADE_LENGTH);
        end else begin
            len_eff = fade_length_reg[LEN_W-1:0];
        end
    end

    // Fade decisions from the current state.
    assign fading     = (mode_reg == MODE_IN) || (mode_reg == MODE_OUT);
    assign at_end     = (pos_reg >= len_eff);
    assign pos_inc    = pos_reg + LEN_W'(1);
    assign num        = (mode_reg == MODE_IN) ? pos_reg : (len_eff - pos_reg);
    assign final_gain = (mode_reg == MODE_IN) ? GAIN_ONE : GAIN_ZERO;

    // Restoring division step: the first step takes the integer bit unshifted.
    assign trial = (div_cnt_reg == '0) ? rem_reg : {rem_reg[LEN_W-1:0], 1'b0};
    assign qbit  = (trial >= {1'b0, len_eff});

    // Shared multiplier, one channel per cycle.
    assign mul_a   = cmd.mul_right ? right_reg : left_reg;
    assign product = mul_a * $signed({1'b0, gain_reg});

    assign status.need_div = fading && !at_end;
    assign status.div_done = (div_cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign status.out_free = !m_valid_reg || m_ready;

    // Configuration and fade control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_length_reg <= FADE_LENGTH_RESET;
            mode_reg        <= MODE_STOP;
            pos_reg         <= '0;
            held_gain_reg   <= GAIN_ZERO;
        end else begin
            if (cfg_wr_en) begin
                fade_length_reg <= cfg_wr_data;
            end
            if (cmd.start) begin
                mode_reg <= fade_direction ? MODE_OUT : MODE_IN;
                pos_reg  <= '0;
            end else if (cmd.load_sample && fading) begin
                if (at_end || (pos_inc >= len_eff)) begin
                    held_gain_reg <= final_gain;
                    mode_reg      <= MODE_STOP;
                end
                if (!at_end) begin
                    pos_reg <= pos_inc;
                end
            end
        end
    end

    // Sample latch, gain choice and serial division.
    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            left_reg    <= left_in;
            right_reg   <= right_in;
            rem_reg     <= {1'b0, num};
            quo_reg     <= '0;
            div_cnt_reg <= '0;
            if (!fading) begin
                gain_reg <= held_gain_reg;
                act_reg  <= 1'b0;
            end else if (at_end) begin
                gain_reg <= final_gain;
                act_reg  <= 1'b0;
            end else begin
                act_reg <= (pos_inc < len_eff);
            end
        end else if (cmd.div_step) begin
            rem_reg     <= qbit ? (trial - {1'b0, len_eff}) : trial;
            quo_reg     <= {quo_reg[GAIN_W-2:0], qbit};
            div_cnt_reg <= div_cnt_reg + CNT_W'(1);
            if (status.div_done) begin
                gain_reg <= {quo_reg[GAIN_W-2:0], qbit};
            end
        end
    end

    // Product register and left result.
    always_ff @(posedge aclk) begin
        if (cmd.mul_left || cmd.mul_right) begin
            prod_reg <= product;
        end
        if (cmd.mul_right) begin
            left_res_reg <= sat_sample(prod_reg);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_left_reg   <= left_res_reg;
            m_right_reg  <= sat_sample(prod_reg);
            m_active_reg <= act_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign left_out    = m_left_reg;
    assign right_out   = m_right_reg;
    assign fade_active = m_active_reg;

    `SLFG_ASSERT_IMP(a_div_rem_bound, cmd.div_step && (div_cnt_reg != '0), rem_reg < {1'b0, len_eff}, "division remainder not below the length")
    `SLFG_ASSERT_IMP(a_active_needs_mode, cmd.load_out && act_reg, mode_reg != MODE_STOP, "active result while fade is stopped")

endmodule

/* rtl/core/stereo_linear_fade_gain_top.sv */
// Channel   Ports                         Contents
// input     s_tvalid/s_tready/s_tdata     requests: sample pair or fade start
//           s_tuser                       kind
// output    m_tvalid/m_tready/m_tdata     scaled sample pair and fade status
// config    cfg_wr_en/cfg_wr_data         fade_length
//
// A sample during a fade takes 17 steps of the serial gain divider, then the left
// and right products on the shared multiplier, then the output register load.
// A sample with a held gain skips the divider; a fade start only sets the mode.
// One request is worked on at a time; the next is taken once the result sits in
// the output register, which holds while m_tready is low.
// Reset is synchronous and active low.
module stereo_linear_fade_gain_top
    import slfg_pkg::*;
#(
    parameter int MAX_FADE_LENGTH = 65536
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    // [0] fade_direction, [24:1] left_in, [48:25] right_in, [55:49] zero
    input  logic [55:0]      s_tdata,
    // [0] kind
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // [23:0] left_out, [47:24] right_out, [48] fade_active, [55:49] zero
    output logic [55:0]      m_tdata
);

    dp_cmd_t                    cmd;
    dp_status_t                 status;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       fade_active;

    // Sequencer.
    slfg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // Gain divider, multiplier and output register.
    slfg_datapath #(
        .MAX_FADE_LENGTH (MAX_FADE_LENGTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .fade_direction (s_tdata[0]),
        .left_in        (s_tdata[24:1]),
        .right_in       (s_tdata[48:25]),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .left_out       (left_out),
        .right_out      (right_out),
        .fade_active    (fade_active)
    );

    assign m_tdata = {7'b0, fade_active, right_out, left_out};

endmodule

/* dv/fade_tb_pkg.sv */
package fade_tb_pkg;

    // Request kinds carried on s_tuser.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_START  = 1'b1;

    // Fade direction carried in bit 0 of s_tdata for a start request.
    localparam logic DIR_IN  = 1'b0;
    localparam logic DIR_OUT = 1'b1;

endpackage

/* dv/fade_gain_check.sv */
module fade_gain_check
    import slfg_pkg::*;
    import fade_tb_pkg::*;
#(
    parameter int MAX_FADE_LENGTH = 65536
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [55:0]      s_tdata,
    input  logic             s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [55:0]      m_tdata,
    output int               fail_count,
    output int               pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       active;
    } scaled_pair_t;

    // Shadow copy of the fade state and the length register.
    logic [CFG_W-1:0]  fade_length = FADE_LENGTH_RESET;
    fade_mode_t        fade_mode   = MODE_STOP;
    logic [CFG_W-1:0]  fade_pos    = '0;
    logic [GAIN_W-1:0] held_gain   = GAIN_ZERO;

    scaled_pair_t scaled_q[$];
    int           mismatches  = 0;
    int           outstanding = 0;

    assign fail_count      = mismatches;
    assign pending_results = outstanding;

    // Sample times Q1.16 gain, floor shift, then clamp to 24 bits.
    function automatic logic signed [SAMPLE_W-1:0] scale_by_gain(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [GAIN_W-1:0]          gain
    );
        longint prod;
        prod = longint'(smp) * longint'(gain);
        prod = prod >>> FRAC_W;
        if (prod > longint'(SAMPLE_MAX)) begin
            prod = longint'(SAMPLE_MAX);
        end else if (prod < longint'(SAMPLE_MIN)) begin
            prod = longint'(SAMPLE_MIN);
        end
        return prod[SAMPLE_W-1:0];
    endfunction

    // Gain for the next sample pair; moves the ramp on by one position.
    task automatic advance_ramp(output logic [GAIN_W-1:0] gain, output logic still_fading);
        logic [CFG_W-1:0] span;
        logic [CFG_W-1:0] num;
        if (fade_length == '0) begin
            span = CFG_W'(1);
        end else if (fade_length > MAX_FADE_LENGTH) begin
            span = CFG_W'(MAX_FADE_LENGTH);
        end else begin
            span = fade_length;
        end
        still_fading = 1'b0;
        if (fade_mode == MODE_IN || fade_mode == MODE_OUT) begin
            if (fade_pos >= span) begin
                // The length shrank under a running fade: it ends before this sample.
                held_gain = (fade_mode == MODE_IN) ? GAIN_ONE : GAIN_ZERO;
                fade_mode = MODE_STOP;
                gain = held_gain;
            end else begin
                num = (fade_mode == MODE_IN) ? fade_pos : span - fade_pos;
                gain = GAIN_W'((longint'(num) << FRAC_W) / longint'(span));
                fade_pos = fade_pos + 1'b1;
                if (fade_pos >= span) begin
                    held_gain = (fade_mode == MODE_IN) ? GAIN_ONE : GAIN_ZERO;
                    fade_mode = MODE_STOP;
                end else begin
                    still_fading = 1'b1;
                end
            end
        end else begin
            gain = held_gain;
        end
    endtask

    task automatic note_mismatch(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("fade check: %s expected %0d, got %0d at %0t", field, want, got, $realtime);
        end
    endtask

    // Track the register, compare finished results, and predict accepted requests.
    always @(posedge aclk) begin
        scaled_pair_t               want;
        logic [GAIN_W-1:0]          gain;
        logic                       fading;
        logic signed [SAMPLE_W-1:0] got_left;
        logic signed [SAMPLE_W-1:0] got_right;
        if (!aresetn) begin
            fade_length = FADE_LENGTH_RESET;
            fade_mode   = MODE_STOP;
            fade_pos    = '0;
            held_gain   = GAIN_ZERO;
            scaled_q.delete();
        end else begin
            if (cfg_wr_en) begin
                fade_length = cfg_wr_data;
            end

            // Result side: each one must match the oldest prediction.
            if (m_tvalid && m_tready) begin
                if (scaled_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("fade check: result 0x%h with no request waiting at %0t",
                            m_tdata, $realtime);
                    end
                end else begin
                    want = scaled_q.pop_front();
                    got_left  = m_tdata[23:0];
                    got_right = m_tdata[47:24];
                    if (got_left !== want.left) begin
                        note_mismatch("left_out", want.left, got_left);
                    end
                    if (got_right !== want.right) begin
                        note_mismatch("right_out", want.right, got_right);
                    end
                    if (m_tdata[48] !== want.active) begin
                        note_mismatch("fade_active", want.active, m_tdata[48]);
                    end
                    if (m_tdata[55:49] !== '0) begin
                        note_mismatch("padding", 0, m_tdata[55:49]);
                    end
                end
            end

            // Request side: a start only changes state, a sample pair yields a result.
            if (s_tvalid && s_tready) begin
                if (s_tuser == KIND_START) begin
                    fade_mode = (s_tdata[0] == DIR_OUT) ? MODE_OUT : MODE_IN;
                    fade_pos  = '0;
                end else begin
                    advance_ramp(gain, fading);
                    want.left   = scale_by_gain(s_tdata[24:1], gain);
                    want.right  = scale_by_gain(s_tdata[48:25], gain);
                    want.active = fading;
                    scaled_q.push_back(want);
                end
            end
        end
        outstanding = scaled_q.size();
    end

endmodule

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import slfg_pkg::*;
    import fade_tb_pkg::*;

    localparam int MAX_LEN   = 65536;
    localparam int N_REQUEST = 1750;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_style_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [55:0]      s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [55:0]      m_tdata;
    int               fail_count;
    int               pending_results;

    int requests_sent = 0;
    int burst_left    = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    stereo_linear_fade_gain_top #(
        .MAX_FADE_LENGTH(MAX_LEN)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    fade_gain_check #(
        .MAX_FADE_LENGTH(MAX_LEN)
    ) gain_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    // Random full-scale samples mixed with the rails and values near zero.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return '1;
            4: return SAMPLE_W'($urandom_range(0, 255));
            5: return -SAMPLE_W'($urandom_range(0, 255));
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Offer one request in bursts with random gaps; returns at the falling edge after it.
    task automatic offer(input logic kind, input logic dir,
                         input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                4, 5, 6:    gap = $urandom_range(1, 6);
                default:    gap = $urandom_range(7, 30);
            endcase
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, right, left, dir};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
        requests_sent++;
    endtask

    task automatic offer_sample(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
        offer(KIND_SAMPLE, 1'($urandom_range(0, 1)), left, right);
    endtask

    task automatic offer_start(input logic dir);
        offer(KIND_START, dir, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
    endtask

    // Drain every pending result, then give a start request time to settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        burst_left = 0;
    endtask

    task automatic load_length(input logic [CFG_W-1:0] len);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result side: stall styles chosen at random for segments of random length, plus two long hold-offs.
    initial begin
        int        cycle_count;
        int        seg_left;
        int        hold_left;
        rx_style_t style;
        cycle_count = 0;
        seg_left    = 0;
        hold_left   = 0;
        style       = RX_ALWAYS;
        m_tready    = 1'b0;
        forever begin
            @(negedge aclk);
            cycle_count++;
            if (cycle_count == 5000 || cycle_count == 30000) begin
                hold_left = 600;
            end
            if (seg_left == 0) begin
                style    = rx_style_t'($urandom_range(0, 3));
                seg_left = $urandom_range(16, 300);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (style)
                    RX_ALWAYS:   m_tready <= 1'b1;
                    RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: m_tready <= ((seg_left % 8) < 3);
                    default:     m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [CFG_W-1:0] len;
        int               span_hint;
        int               n_samples;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = KIND_SAMPLE;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Straight after reset the block is stopped with a zero gain.
        offer_sample(SAMPLE_MAX, SAMPLE_MIN);
        // Fade-in and fade-out over the reset length, then a restart in mid-fade.
        offer_start(DIR_IN);
        offer_sample(SAMPLE_MAX, SAMPLE_MIN);
        offer_sample('1, 24'd1);
        offer_start(DIR_OUT);
        offer_sample(SAMPLE_MAX, SAMPLE_MIN);
        offer_start(DIR_OUT);
        offer_sample(24'h123456, 24'hFEDCBA);
        // A one-sample ramp ends on its first sample, then the held gain applies.
        load_length(CFG_W'(1));
        offer_start(DIR_IN);
        offer_sample(SAMPLE_MIN, SAMPLE_MAX);
        offer_sample(SAMPLE_MIN, SAMPLE_MAX);
        offer_start(DIR_OUT);
        offer_sample(SAMPLE_MAX, SAMPLE_MAX);
        offer_sample(SAMPLE_MAX, SAMPLE_MAX);
        // A zero length is clamped up, an oversized one clamped down.
        load_length('0);
        offer_start(DIR_IN);
        offer_sample(SAMPLE_MAX, '1);
        load_length('1);
        offer_start(DIR_OUT);
        offer_sample(SAMPLE_MIN, 24'h7FF00F);
        // Shortening the length under a running fade ends it before the next sample.
        load_length(CFG_W'(40));
        offer_start(DIR_IN);
        offer_sample(24'h400000, 24'hC00000);
        offer_sample(24'h400000, 24'hC00000);
        offer_sample(24'h400000, 24'hC00000);
        load_length(CFG_W'(2));
        offer_sample(24'h400000, 24'hC00000);

        // Random phases: a new length each, then fade starts with runs of random samples.
        while (requests_sent < N_REQUEST) begin
            case ($urandom_range(0, 11))
                0:       len = '0;
                1:       len = CFG_W'(1);
                2:       len = CFG_W'(MAX_LEN);
                3:       len = '1;
                4:       len = CFG_W'($urandom_range(MAX_LEN + 1, 131071));
                5:       len = CFG_W'($urandom());
                6:       len = FADE_LENGTH_RESET;
                default: len = CFG_W'($urandom_range(2, 48));
            endcase
            load_length(len);
            span_hint = (len == '0) ? 1 : (len > 48) ? 48 : int'(len);
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 5) != 0) begin
                    offer_start(1'($urandom_range(0, 1)));
                    n_samples = $urandom_range(1, span_hint + 4);
                    repeat (n_samples) begin
                        if ($urandom_range(0, 39) == 0) begin
                            offer_start(1'($urandom_range(0, 1)));
                        end
                        offer_sample(pick_sample(), pick_sample());
                    end
                end else begin
                    repeat ($urandom_range(1, 8)) begin
                        offer(($urandom_range(0, 3) == 0) ? KIND_START : KIND_SAMPLE,
                            1'($urandom_range(0, 1)), pick_sample(), pick_sample());
                    end
                end
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #10ms;
        $display("testbench: errors");
        $finish;
    end

endmodule
